@@ hdl/itp_pkg.sv @@
// Shared types, constants and the digit table for the integer-to-text formatter.
// No dependencies; files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package itp_pkg;

	localparam int MAX_FIELD_WIDTH_DEF = 64;
	localparam int NUM_DIGITS          = 20;
	localparam int DIGIT_IDX_W         = 5;
	localparam int SHIFT_CNT_W         = 7;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	localparam logic [SHIFT_CNT_W-1:0] BITS_LONG  = 7'd64;
	localparam logic [SHIFT_CNT_W-1:0] BITS_SHORT = 7'd32;

	typedef struct packed {
		logic [63:0] mag;
		logic        neg;
		logic        hex;
		logic        long_m;
		logic        left;
		logic        zfill;
	} item_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		case (d)
			4'h0: c = 8'h30;
			4'h1: c = 8'h31;
			4'h2: c = 8'h32;
			4'h3: c = 8'h33;
			4'h4: c = 8'h34;
			4'h5: c = 8'h35;
			4'h6: c = 8'h36;
			4'h7: c = 8'h37;
			4'h8: c = 8'h38;
			4'h9: c = 8'h39;
			4'hA: c = 8'h41;
			4'hB: c = 8'h42;
			4'hC: c = 8'h43;
			4'hD: c = 8'h44;
			4'hE: c = 8'h45;
			default: c = 8'h46;
		endcase
		return c;
	endfunction

endpackage

@@ hdl/itp_ifs.sv @@
// Valid/ready channel interfaces: number requests in, text characters out.
// No dependencies.
`timescale 1ns / 1ps

interface itp_num_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] value;
	logic               long_mode;
	logic               hex_base;
	logic               treat_unsigned;
	logic               left_justify;
	logic               zero_fill;
	logic        [6:0]  field_width;

	modport source (output valid, value, long_mode, hex_base, treat_unsigned,
		left_justify, zero_fill, field_width, input ready);
	modport sink (input valid, value, long_mode, hex_base, treat_unsigned,
		left_justify, zero_fill, field_width, output ready);
endinterface

interface itp_txt_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       final_char;

	modport source (output valid, text_char, final_char, input ready);
	modport sink (input valid, text_char, final_char, output ready);
endinterface

@@ hdl/itp_front.sv @@
// Front end: accepts a number request, picks operand width and sign, takes the
// magnitude and saturates the field width. Depends on itp_pkg and itp_num_if.
`timescale 1ns / 1ps

module itp_front #(
	parameter int MAX_FIELD_WIDTH = itp_pkg::MAX_FIELD_WIDTH_DEF,
	parameter int WW = $clog2(MAX_FIELD_WIDTH + 1)
) (
	itp_num_if.sink         number,
	output logic            push_valid,
	input  logic            push_ready,
	output itp_pkg::item_t  push_item,
	output logic [WW-1:0]   push_width
);

	logic [63:0] raw_mag;
	logic        sign_bit;
	logic        neg;

	assign number.ready = push_ready;
	assign push_valid   = number.valid;

	always_comb begin
		raw_mag  = number.long_mode ? number.value : {32'b0, number.value[31:0]};
		sign_bit = number.long_mode ? number.value[63] : number.value[31];
		neg      = sign_bit && !number.treat_unsigned && !number.hex_base;

		push_item.neg    = neg;
		push_item.hex    = number.hex_base;
		push_item.long_m = number.long_mode;
		push_item.left   = number.left_justify;
		push_item.zfill  = number.zero_fill;
		if (!neg) begin
			push_item.mag = raw_mag;
		end else if (number.long_mode) begin
			push_item.mag = 64'd0 - raw_mag;
		end else begin
			push_item.mag = {32'b0, 32'd0 - raw_mag[31:0]};
		end

		if (number.field_width > 7'(MAX_FIELD_WIDTH)) begin
			push_width = WW'(MAX_FIELD_WIDTH);
		end else begin
			push_width = WW'(number.field_width);
		end
	end

endmodule

@@ hdl/itp_queue.sv @@
// Two-entry request queue between front end and back end.
// Generic payload vector; no package dependencies.
`timescale 1ns / 1ps

module itp_queue #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  logic [DW-1:0] push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output logic [DW-1:0] pop_data
);

	logic [DW-1:0] entry_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = entry_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= push_data;
	end

endmodule

@@ hdl/itp_back.sv @@
// Back end: binary-to-BCD conversion one bit per cycle (decimal only),
// digit count, then emission of leading pad, sign, digits and trailing
// pad through an output register. Depends on itp_pkg and itp_txt_if.
`timescale 1ns / 1ps

module itp_back #(
	parameter int MAX_FIELD_WIDTH = itp_pkg::MAX_FIELD_WIDTH_DEF,
	parameter int WW = $clog2(MAX_FIELD_WIDTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  itp_pkg::item_t pop_item,
	input  logic [WW-1:0]  pop_width,
	itp_txt_if.source      text
);

	localparam int CW = (WW > itp_pkg::DIGIT_IDX_W) ? WW : itp_pkg::DIGIT_IDX_W;
	localparam int BW = 4 * itp_pkg::NUM_DIGITS;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_CONV = 7'b0000010,
		ST_SIZE = 7'b0000100,
		ST_PRE  = 7'b0001000,
		ST_SIGN = 7'b0010000,
		ST_DIG  = 7'b0100000,
		ST_POST = 7'b1000000
	} state_t;

	state_t                            state_q;
	logic [63:0]                       bin_q;
	logic [BW-1:0]                     bcd_q;
	logic [itp_pkg::SHIFT_CNT_W-1:0]   cnt_q;
	logic                              neg_q;
	logic                              left_q;
	logic                              zfill_q;
	logic [WW-1:0]                     width_q;
	logic [WW-1:0]                     pad_q;
	logic [itp_pkg::DIGIT_IDX_W-1:0]   di_q;
	logic                              ovalid_q;
	logic [7:0]                        ochar_q;
	logic                              ofinal_q;

	logic [BW-1:0]                     adj;
	logic [itp_pkg::DIGIT_IDX_W-1:0]   nd;
	logic [itp_pkg::DIGIT_IDX_W-1:0]   textlen;
	logic [WW-1:0]                     pad_n;
	logic                              ofree;
	logic                              emit;
	logic [7:0]                        char_n;
	logic                              final_n;
	logic [7:0]                        pad_char;
	logic                              has_post;

	assign pop_ready       = (state_q == ST_IDLE);
	assign text.valid      = ovalid_q;
	assign text.text_char  = ochar_q;
	assign text.final_char = ofinal_q;
	assign ofree           = !ovalid_q || text.ready;
	assign pad_char        = zfill_q ? itp_pkg::CHAR_ZERO : itp_pkg::CHAR_SPACE;
	assign has_post        = left_q && (pad_q != '0);

	always_comb begin
		for (int i = 0; i < itp_pkg::NUM_DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_comb begin
		nd = '0;
		for (int i = 0; i < itp_pkg::NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) nd = itp_pkg::DIGIT_IDX_W'(i + 1);
		end
		if (nd == '0) nd = itp_pkg::DIGIT_IDX_W'(1);
		textlen = nd + {{(itp_pkg::DIGIT_IDX_W-1){1'b0}}, neg_q};
		if (CW'(width_q) > CW'(textlen)) begin
			pad_n = WW'(CW'(width_q) - CW'(textlen));
		end else begin
			pad_n = '0;
		end
	end

	always_comb begin
		emit    = 1'b0;
		char_n  = pad_char;
		final_n = 1'b0;
		case (state_q)
			ST_PRE: begin
				emit = ofree;
			end
			ST_SIGN: begin
				emit   = ofree;
				char_n = itp_pkg::CHAR_MINUS;
			end
			ST_DIG: begin
				emit    = ofree;
				char_n  = itp_pkg::digit_char(bcd_q[4*di_q +: 4]);
				final_n = (di_q == '0) && !has_post;
			end
			ST_POST: begin
				emit    = ofree;
				final_n = (pad_q == WW'(1));
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (text.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) state_q <= pop_item.hex ? ST_SIZE : ST_CONV;
				end
				ST_CONV: begin
					if (cnt_q == itp_pkg::SHIFT_CNT_W'(1)) state_q <= ST_SIZE;
				end
				ST_SIZE: begin
					if (!left_q && pad_n != '0) begin
						state_q <= ST_PRE;
					end else if (neg_q) begin
						state_q <= ST_SIGN;
					end else begin
						state_q <= ST_DIG;
					end
				end
				ST_PRE: begin
					if (emit && pad_q == WW'(1)) state_q <= neg_q ? ST_SIGN : ST_DIG;
				end
				ST_SIGN: begin
					if (emit) state_q <= ST_DIG;
				end
				ST_DIG: begin
					if (emit && di_q == '0) state_q <= has_post ? ST_POST : ST_IDLE;
				end
				ST_POST: begin
					if (emit && pad_q == WW'(1)) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ochar_q  <= char_n;
			ofinal_q <= final_n;
		end
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					bin_q   <= pop_item.long_m ? pop_item.mag : {pop_item.mag[31:0], 32'b0};
					bcd_q   <= pop_item.hex ? {{(BW-64){1'b0}}, pop_item.mag} : '0;
					cnt_q   <= pop_item.long_m ? itp_pkg::BITS_LONG : itp_pkg::BITS_SHORT;
					neg_q   <= pop_item.neg;
					left_q  <= pop_item.left;
					zfill_q <= pop_item.zfill;
					width_q <= pop_width;
				end
			end
			ST_CONV: begin
				bcd_q <= {adj[BW-2:0], bin_q[63]};
				bin_q <= {bin_q[62:0], 1'b0};
				cnt_q <= cnt_q - itp_pkg::SHIFT_CNT_W'(1);
			end
			ST_SIZE: begin
				pad_q <= pad_n;
				di_q  <= nd - itp_pkg::DIGIT_IDX_W'(1);
			end
			ST_PRE: begin
				if (emit) pad_q <= pad_q - WW'(1);
			end
			ST_DIG: begin
				if (emit && di_q != '0) di_q <= di_q - itp_pkg::DIGIT_IDX_W'(1);
			end
			ST_POST: begin
				if (emit) pad_q <= pad_q - WW'(1);
			end
			default: begin
				di_q <= di_q;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_conv_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> (cnt_q != '0))
		else $error("conversion running with zero bit count");
	a_pad_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PRE || state_q == ST_POST) |-> (pad_q != '0))
		else $error("pad state entered with no pad left");
	a_sign_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIGN) |-> neg_q)
		else $error("sign emitted for non-negative request");
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && final_n) |=> (state_q == ST_IDLE))
		else $error("last character emitted but text not finished");
`endif

endmodule

@@ hdl/integer_to_padded_text.sv @@
// Top level of the integer-to-text formatter: front end, request queue, back end.
// Depends on itp_pkg, itp_ifs, itp_front, itp_queue and itp_back.
//
// Usage:
//   number: valid/ready channel, one request per handshake: a 64-bit value plus
//     width, base, sign, justify, fill flags and a field width (saturated to
//     MAX_FIELD_WIDTH).
//   text: valid/ready channel, one ASCII character per handshake, most
//     significant first; final_char marks the last character of a request.
//   A two-entry queue sits between the front end and the back end, so up to
//   two requests are taken while the back end is still busy.
//   Per request the back end loads it, converts it, sizes the text and then
//   emits each character. Conversion is the shift-and-add-3 BCD loop, one
//   operand bit per cycle, and is skipped in hex. The character count is
//   max(text length, field width), at most 64.
//   When the receiver stalls, the output register holds its character and the
//   back end waits; the queue keeps taking requests until it is full.
//   Reset clears the queue, the back end state and the output valid.
`timescale 1ns / 1ps

module integer_to_padded_text #(
	parameter int MAX_FIELD_WIDTH = itp_pkg::MAX_FIELD_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	itp_num_if.sink   number,
	itp_txt_if.source text
);

	localparam int WW = $clog2(MAX_FIELD_WIDTH + 1);
	localparam int IW = $bits(itp_pkg::item_t);
	localparam int DW = IW + WW;

	logic           push_valid;
	logic           push_ready;
	itp_pkg::item_t push_item;
	logic [WW-1:0]  push_width;
	logic           pop_valid;
	logic           pop_ready;
	logic [DW-1:0]  pop_data;
	itp_pkg::item_t pop_item;
	logic [WW-1:0]  pop_width;

	assign pop_item  = itp_pkg::item_t'(pop_data[DW-1:WW]);
	assign pop_width = pop_data[WW-1:0];

	itp_front #(
		.MAX_FIELD_WIDTH(MAX_FIELD_WIDTH),
		.WW(WW)
	) u_front (
		.number(number),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item(push_item),
		.push_width(push_width)
	);

	itp_queue #(
		.DW(DW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data({push_item, push_width}),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	itp_back #(
		.MAX_FIELD_WIDTH(MAX_FIELD_WIDTH),
		.WW(WW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item(pop_item),
		.pop_width(pop_width),
		.text(text)
	);

endmodule

@@ bench/integer_to_padded_text_test.sv @@
// Testbench for integer_to_padded_text: drives number requests, predicts the text, checks each character.
// Depends on itp_pkg, itp_ifs and the formatter RTL; needs no files or arguments.
`timescale 1ns / 1ps

module integer_to_padded_text_test;

	localparam int         FIELD_LIMIT   = itp_pkg::MAX_FIELD_WIDTH_DEF;
	localparam int         IDLE_LIMIT    = 4000;
	localparam int         SETTLE_CYCLES = 100;
	localparam int         RANDOM_COUNT  = 260;
	localparam logic [7:0] CHAR_UPPER_A  = 8'h41;

	typedef struct {
		logic [63:0] value;
		logic        long_mode;
		logic        hex_base;
		logic        treat_unsigned;
		logic        left_justify;
		logic        zero_fill;
		logic [6:0]  field_width;
		logic        drain;
	} num_req_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	logic clk;
	logic arst_n;

	itp_num_if num_ch ();
	itp_txt_if txt_ch ();

	integer_to_padded_text #(
		.MAX_FIELD_WIDTH(FIELD_LIMIT)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.number(num_ch),
		.text  (txt_ch)
	);

	num_req_t   req_queue[$];
	text_char_t text_due[$];
	int         chars_due      = 0;
	int         mismatch_count = 0;
	int         burst_left     = 1;
	int         gap_left       = 0;
	int         ready_mode     = 0;
	int         phase_left     = 0;
	int         idle_cycles    = 0;
	int         tick           = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatch_count < 100)
			$display("%0t ns %s: got %0h expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	function automatic num_req_t make_req(input logic [63:0] value, input logic long_mode,
		input logic hex_base, input logic treat_unsigned, input logic left_justify,
		input logic zero_fill, input logic [6:0] field_width, input logic drain);
		num_req_t r;
		r.value          = value;
		r.long_mode      = long_mode;
		r.hex_base       = hex_base;
		r.treat_unsigned = treat_unsigned;
		r.left_justify   = left_justify;
		r.zero_fill      = zero_fill;
		r.field_width    = field_width;
		r.drain          = drain;
		return r;
	endfunction

	// Append the characters of one request to text_due.
	function automatic void format_number(input num_req_t r);
		logic [63:0] mag;
		logic        neg;
		logic [3:0]  d;
		logic [7:0]  pad;
		logic [7:0]  body[$];
		logic [7:0]  line[$];
		int          width;
		int          n;
		text_char_t  tc;
		width = (r.field_width > FIELD_LIMIT) ? FIELD_LIMIT : int'(r.field_width);
		pad   = r.zero_fill ? itp_pkg::CHAR_ZERO : itp_pkg::CHAR_SPACE;
		if (r.long_mode) begin
			mag = r.value;
			neg = r.value[63];
		end else begin
			mag = {32'd0, r.value[31:0]};
			neg = r.value[31];
		end
		if (r.treat_unsigned || r.hex_base)
			neg = 1'b0;
		if (neg) begin
			mag = 64'd0 - mag;
			if (!r.long_mode)
				mag[63:32] = 32'd0;
		end
		do begin
			if (r.hex_base) begin
				d   = mag[3:0];
				mag = mag >> 4;
			end else begin
				d   = 4'(mag % 64'd10);
				mag = mag / 64'd10;
			end
			body.push_front((d < 4'd10) ? itp_pkg::CHAR_ZERO + 8'(d) : CHAR_UPPER_A + 8'(d) - 8'd10);
		end while (mag != 64'd0);
		if (neg)
			body.push_front(itp_pkg::CHAR_MINUS);
		line = body;
		for (n = body.size(); n < width; n++) begin
			if (r.left_justify)
				line.push_back(pad);
			else
				line.push_front(pad);
		end
		foreach (line[i]) begin
			tc.ch   = line[i];
			tc.last = (i == line.size() - 1);
			text_due.push_back(tc);
		end
	endfunction

	// Driver: present pending requests in bursts with random gaps.
	always @(posedge clk or negedge arst_n) begin : drive_requests
		num_req_t head;
		if (!arst_n) begin
			num_ch.valid          <= 1'b0;
			num_ch.value          <= '0;
			num_ch.long_mode      <= 1'b0;
			num_ch.hex_base       <= 1'b0;
			num_ch.treat_unsigned <= 1'b0;
			num_ch.left_justify   <= 1'b0;
			num_ch.zero_fill      <= 1'b0;
			num_ch.field_width    <= '0;
		end else if (!num_ch.valid || num_ch.ready) begin
			if (gap_left > 0) begin
				gap_left--;
				num_ch.valid <= 1'b0;
			end else if (req_queue.size() != 0 &&
					!(req_queue[0].drain && (num_ch.valid || chars_due != 0))) begin
				head = req_queue.pop_front();
				num_ch.valid          <= 1'b1;
				num_ch.value          <= head.value;
				num_ch.long_mode      <= head.long_mode;
				num_ch.hex_base       <= head.hex_base;
				num_ch.treat_unsigned <= head.treat_unsigned;
				num_ch.left_justify   <= head.left_justify;
				num_ch.zero_fill      <= head.zero_fill;
				num_ch.field_width    <= head.field_width;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: gap_left = $urandom_range(0, 2);
						6, 7, 8:          gap_left = $urandom_range(3, 20);
						default:          gap_left = $urandom_range(21, 100);
					endcase
				end
			end else begin
				num_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: switch among stall patterns, each held for a randomly chosen phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txt_ch.ready <= 1'b0;
		end else begin
			tick++;
			if (phase_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				phase_left = $urandom_range(50, 400);
			end else begin
				phase_left--;
			end
			case (ready_mode)
				0:       txt_ch.ready <= 1'b1;
				1:       txt_ch.ready <= ($urandom_range(0, 3) != 0);
				2:       txt_ch.ready <= ($urandom_range(0, 3) == 0);
				default: txt_ch.ready <= (tick % 7 < 4);
			endcase
		end
	end

	// Monitor: check delivered characters, then predict for a newly taken request.
	always @(posedge clk or negedge arst_n) begin : check_text
		text_char_t want;
		num_req_t   taken;
		if (!arst_n) begin
			chars_due <= 0;
		end else begin
			if (txt_ch.valid && txt_ch.ready) begin
				if (text_due.size() == 0) begin
					report_mismatch("unexpected character",
						64'({txt_ch.final_char, txt_ch.text_char}), 64'd0);
				end else begin
					want = text_due.pop_front();
					if (txt_ch.text_char !== want.ch)
						report_mismatch("text_char", 64'(txt_ch.text_char), 64'(want.ch));
					if (txt_ch.final_char !== want.last)
						report_mismatch("final_char", 64'(txt_ch.final_char), 64'(want.last));
				end
			end
			if (num_ch.valid && num_ch.ready) begin
				taken = make_req(num_ch.value, num_ch.long_mode, num_ch.hex_base,
					num_ch.treat_unsigned, num_ch.left_justify, num_ch.zero_fill,
					num_ch.field_width, 1'b0);
				format_number(taken);
			end
			chars_due <= text_due.size();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((num_ch.valid && num_ch.ready) || (txt_ch.valid && txt_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [63:0] v;
		logic [6:0]  w;
		arst_n = 1'b0;

		req_queue.push_back(make_req(64'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0));
		req_queue.push_back(make_req(64'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 7'd1, 1'b0));
		req_queue.push_back(make_req(64'h0000_0000_7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
			7'd0, 1'b0));
		req_queue.push_back(make_req(64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
			7'd0, 1'b0));
		req_queue.push_back(make_req(64'h1234_5678_8000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
			7'd12, 1'b0));
		req_queue.push_back(make_req(64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
			7'd0, 1'b0));
		req_queue.push_back(make_req(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
			7'd0, 1'b0));
		req_queue.push_back(make_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
			7'd0, 1'b0));
		req_queue.push_back(make_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
			7'd0, 1'b0));
		req_queue.push_back(make_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
			7'd0, 1'b0));
		req_queue.push_back(make_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
			7'd0, 1'b0));
		req_queue.push_back(make_req(-64'sd5, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd5, 1'b1));
		req_queue.push_back(make_req(-64'sd5, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 7'd6, 1'b0));
		req_queue.push_back(make_req(64'd12345, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 7'd10, 1'b0));
		req_queue.push_back(make_req(64'd255, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 7'd4, 1'b0));
		req_queue.push_back(make_req(64'd7, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 7'd64, 1'b0));
		req_queue.push_back(make_req(-64'sd42, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 7'd127, 1'b0));
		req_queue.push_back(make_req(64'd99, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 7'd65, 1'b0));
		req_queue.push_back(make_req(64'd123456789, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd3, 1'b0));
		req_queue.push_back(make_req(64'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 7'd64, 1'b0));
		req_queue.push_back(make_req(-64'sd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 7'd2, 1'b0));
		req_queue.push_back(make_req(64'hABCD_EF01_2345_6789, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
			7'd20, 1'b0));
		req_queue.push_back(make_req(64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
			7'd0, 1'b0));
		req_queue.push_back(make_req(-64'sd300, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 7'd9, 1'b0));

		for (int i = 0; i < RANDOM_COUNT; i++) begin
			case ($urandom_range(0, 3))
				0:       v = {$urandom, $urandom};
				1:       v = 64'(int'($urandom_range(0, 2000)) - 1000);
				2:       v = {{32{1'b0}}, $urandom};
				default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
			endcase
			if ($urandom_range(0, 3) == 0)
				v = 64'd0 - v;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: w = 7'($urandom_range(0, 24));
				7, 8:                w = 7'($urandom_range(25, 64));
				default:             w = 7'($urandom_range(65, 127));
			endcase
			req_queue.push_back(make_req(v, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), w,
				$urandom_range(0, 39) == 0));
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (req_queue.size() != 0 || num_ch.valid || chars_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (text_due.size() != 0)
			report_mismatch("characters never delivered", 64'd0, 64'(text_due.size()));

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
